@@ design/rgbhsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Types and fixed widths shared by the RGB888 to HSL converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  // Width of one colour channel and of each result field.
  localparam int CH_W   = 8;
  // Quotient width of both dividers; every result is below 256.
  localparam int Q_W    = 8;
  // Hue division: 255*n with n below 1530, divisor 6*d up to 1530.
  localparam int HNUM_W = 19;
  localparam int HDEN_W = 11;
  // Saturation division: 255*d up to 65025, divisor up to 256.
  localparam int SNUM_W = 16;
  localparam int SDEN_W = 9;
  // Channel sum M+m, up to 510.
  localparam int SUM_W  = 9;

  // Input word: one pixel.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_in_t;

  // Result word: one HSL triple.
  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] lightness;
  } pix_out_t;

  // Operands handed to the divider pipeline for one pixel.
  typedef struct packed {
    logic [HNUM_W-1:0] hnum;
    logic [HDEN_W-1:0] hden;
    logic [SNUM_W-1:0] snum;
    logic [SDEN_W-1:0] sden;
    logic [CH_W-1:0]   lig;
  } div_job_t;

endpackage

@@ design/rgbhsl_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_div_pipe
// Pipelined restoring divider pair: one quotient bit of the hue and of the
// saturation division per stage, Q_W stages, one job entering every cycle.
// ----------------------------------------------------------------------------
module rgbhsl_div_pipe
  import rgbhsl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  input  div_job_t job,
  output logic     res_valid,
  output pix_out_t res
);

  // Stage registers; index j holds a job that has finished j steps.
  logic              v_r    [1:Q_W];
  logic [HNUM_W-1:0] hrem_r [1:Q_W];
  logic [HDEN_W-1:0] hden_r [1:Q_W];
  logic [SNUM_W-1:0] srem_r [1:Q_W];
  logic [SDEN_W-1:0] sden_r [1:Q_W];
  logic [Q_W-1:0]    hq_r   [1:Q_W];
  logic [Q_W-1:0]    sq_r   [1:Q_W];
  logic [CH_W-1:0]   lig_r  [1:Q_W];

  // Step inputs: the incoming job for step 0, the stage register after that.
  logic              v_s    [0:Q_W-1];
  logic [HNUM_W-1:0] hrem_s [0:Q_W-1];
  logic [HDEN_W-1:0] hden_s [0:Q_W-1];
  logic [SNUM_W-1:0] srem_s [0:Q_W-1];
  logic [SDEN_W-1:0] sden_s [0:Q_W-1];
  logic [Q_W-1:0]    hq_s   [0:Q_W-1];
  logic [Q_W-1:0]    sq_s   [0:Q_W-1];
  logic [CH_W-1:0]   lig_s  [0:Q_W-1];

  logic [HNUM_W-1:0] hrem_nxt [1:Q_W];
  logic [SNUM_W-1:0] srem_nxt [1:Q_W];
  logic [Q_W-1:0]    hq_nxt   [1:Q_W];
  logic [Q_W-1:0]    sq_nxt   [1:Q_W];

  // The first step works on the job itself, later steps on the stage before.
  always_comb begin
    v_s[0]    = job_valid;
    hrem_s[0] = job.hnum;
    hden_s[0] = job.hden;
    srem_s[0] = job.snum;
    sden_s[0] = job.sden;
    hq_s[0]   = '0;
    sq_s[0]   = '0;
    lig_s[0]  = job.lig;
    for (int j = 1; j < Q_W; j++) begin
      v_s[j]    = v_r[j];
      hrem_s[j] = hrem_r[j];
      hden_s[j] = hden_r[j];
      srem_s[j] = srem_r[j];
      sden_s[j] = sden_r[j];
      hq_s[j]   = hq_r[j];
      sq_s[j]   = sq_r[j];
      lig_s[j]  = lig_r[j];
    end
  end

  // One compare and subtract per stage; stage j settles quotient bit Q_W-1-j.
  always_comb begin
    logic [HNUM_W-1:0] hsub;
    logic [SNUM_W-1:0] ssub;
    logic              hbit;
    logic              sbit;
    for (int j = 0; j < Q_W; j++) begin
      hsub = HNUM_W'(hden_s[j]) << (Q_W - 1 - j);
      ssub = SNUM_W'(sden_s[j]) << (Q_W - 1 - j);
      hbit = (hrem_s[j] >= hsub);
      sbit = (srem_s[j] >= ssub);
      hrem_nxt[j+1] = hbit ? (hrem_s[j] - hsub) : hrem_s[j];
      srem_nxt[j+1] = sbit ? (srem_s[j] - ssub) : srem_s[j];
      hq_nxt[j+1]   = {hq_s[j][Q_W-2:0], hbit};
      sq_nxt[j+1]   = {sq_s[j][Q_W-2:0], sbit};
    end
  end

  // Valid bits travel with the data; only they are reset.
  always_ff @(posedge clk) begin
    for (int j = 1; j <= Q_W; j++) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_s[j-1];
      end
      hrem_r[j] <= hrem_nxt[j];
      srem_r[j] <= srem_nxt[j];
      hq_r[j]   <= hq_nxt[j];
      sq_r[j]   <= sq_nxt[j];
      hden_r[j] <= hden_s[j-1];
      sden_r[j] <= sden_s[j-1];
      lig_r[j]  <= lig_s[j-1];
    end
  end

  assign res_valid      = v_r[Q_W];
  assign res.hue        = hq_r[Q_W];
  assign res.saturation = sq_r[Q_W];
  assign res.lightness  = lig_r[Q_W];

  // The hue quotient fitted in Q_W bits: the final remainder is below the divisor.
  a_hue_rem : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[Q_W] |-> (hrem_r[Q_W] < HNUM_W'(hden_r[Q_W])))
    else $error("hue remainder not below divisor");

  // Likewise for the saturation quotient.
  a_sat_rem : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[Q_W] |-> (srem_r[Q_W] < SNUM_W'(sden_r[Q_W])))
    else $error("saturation remainder not below divisor");

  // A job in the last step reaches the output in the following cycle.
  a_valid_flow : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (v_r[Q_W] == $past(v_r[Q_W-1])))
    else $error("valid bit lost or invented in divider pipeline");

endmodule

@@ design/rgb888_to_hsl_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb888_to_hsl_converter
// Converts one RGB888 pixel into an 8-bit hue, saturation and lightness word.
// ----------------------------------------------------------------------------
//  Channel  Ports                       Handshake
//  input    start, busy, in_pixel       word taken when start and not busy
//  result   out_strobe, out_pixel       word valid for the one strobed cycle
//
// A pixel can be taken on every clock cycle; busy is held low.
// A word passes through an input register, three operand stages and one stage
// per quotient bit of the divider pair, twelve stages in all; the result
// strobe is the valid bit of the last stage.
// Synchronous reset clears the valid bits only; words in flight are dropped.
// The receiver cannot stall, so no stage ever holds.
// ----------------------------------------------------------------------------
module rgb888_to_hsl_converter
  import rgbhsl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pix_in_t  in_pixel,
  output logic     out_strobe,
  output pix_out_t out_pixel
);

  logic accept;

  // Stage 1: input register.
  logic    v1_r;
  pix_in_t pix1_r;

  // Stage 2: extremes and the winning channel.
  logic            v2_r;
  pix_in_t         pix2_r;
  logic [CH_W-1:0] hi2_r, lo2_r;
  logic            rmax2_r, gmax2_r;
  logic [CH_W-1:0] hi2_nxt, lo2_nxt;

  // Stage 3: difference, sum, hue offset, saturation divisor, lightness.
  logic              v3_r;
  logic [CH_W-1:0]   d3_r, lig3_r;
  logic [HDEN_W-1:0] n3_r;
  logic [SDEN_W-1:0] den3_r;
  logic [CH_W-1:0]   d3_nxt, lig3_nxt;
  logic [HDEN_W-1:0] n3_nxt, d3w;
  logic [SDEN_W-1:0] den3_nxt;
  logic [SUM_W-1:0]  sum3;
  logic [SUM_W+7:0]  lprod3;

  // Stage 4: divider operands.
  logic     v4_r;
  div_job_t job4_r, job4_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Take the incoming word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    pix1_r <= in_pixel;
  end

  // Largest and smallest channel.
  always_comb begin
    hi2_nxt = pix1_r.red;
    if (pix1_r.green > hi2_nxt) hi2_nxt = pix1_r.green;
    if (pix1_r.blue  > hi2_nxt) hi2_nxt = pix1_r.blue;
    lo2_nxt = pix1_r.red;
    if (pix1_r.green < lo2_nxt) lo2_nxt = pix1_r.green;
    if (pix1_r.blue  < lo2_nxt) lo2_nxt = pix1_r.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    pix2_r  <= pix1_r;
    hi2_r   <= hi2_nxt;
    lo2_r   <= lo2_nxt;
    rmax2_r <= (pix1_r.red == hi2_nxt);
    gmax2_r <= (pix1_r.green == hi2_nxt);
  end

  // Hue offset by winning channel; red wins ties, then green.
  always_comb begin
    d3_nxt = hi2_r - lo2_r;
    d3w    = HDEN_W'(d3_nxt);
    sum3   = SUM_W'(hi2_r) + SUM_W'(lo2_r);
    if (rmax2_r) begin
      if (pix2_r.green >= pix2_r.blue) begin
        n3_nxt = HDEN_W'(pix2_r.green) - HDEN_W'(pix2_r.blue);
      end else begin
        n3_nxt = (d3w << 2) + (d3w << 1) - (HDEN_W'(pix2_r.blue) - HDEN_W'(pix2_r.green));
      end
    end else if (gmax2_r) begin
      n3_nxt = (d3w << 1) + HDEN_W'(pix2_r.blue) - HDEN_W'(pix2_r.red);
    end else begin
      n3_nxt = (d3w << 2) + HDEN_W'(pix2_r.red) - HDEN_W'(pix2_r.green);
    end
    // Divisor is the sum in the dark half and 512 minus the sum in the light half.
    if (sum3 < SUM_W'(256)) begin
      den3_nxt = sum3;
    end else begin
      den3_nxt = SDEN_W'(10'd512 - {1'b0, sum3});
    end
    // Lightness: 255*M/256 for grey, 255*(M+m)/512 otherwise.
    lprod3 = {sum3, 8'd0} - (SUM_W + 8)'(sum3);
    if (d3_nxt == '0) begin
      lig3_nxt = (hi2_r == '0) ? '0 : hi2_r - CH_W'(1);
    end else begin
      lig3_nxt = lprod3[SUM_W+7:9];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    d3_r   <= d3_nxt;
    n3_r   <= n3_nxt;
    den3_r <= den3_nxt;
    lig3_r <= lig3_nxt;
  end

  // Scale numerators by 255 and form 6*d; grey pixels divide zero by one.
  always_comb begin
    job4_nxt.lig = lig3_r;
    if (d3_r == '0) begin
      job4_nxt.hnum = '0;
      job4_nxt.hden = HDEN_W'(1);
      job4_nxt.snum = '0;
      job4_nxt.sden = SDEN_W'(1);
    end else begin
      job4_nxt.hnum = (HNUM_W'(n3_r) << 8) - HNUM_W'(n3_r);
      job4_nxt.hden = (HDEN_W'(d3_r) << 2) + (HDEN_W'(d3_r) << 1);
      job4_nxt.snum = (SNUM_W'(d3_r) << 8) - SNUM_W'(d3_r);
      job4_nxt.sden = den3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    job4_r <= job4_nxt;
  end

  // Bit-per-stage division of hue and saturation.
  rgbhsl_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (v4_r),
    .job       (job4_r),
    .res_valid (out_strobe),
    .res       (out_pixel)
  );

endmodule

@@ test/rgb888_to_hsl_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb888_to_hsl_converter_tb
// Self-checking bench for the RGB888 to HSL converter. Pixel words go in under
// the start/busy handshake with random gaps. Each accepted word queues its
// predicted HSL word. Every strobed result word is checked field by field
// against the oldest queued prediction.
// ----------------------------------------------------------------------------
module rgb888_to_hsl_converter_tb
  import rgbhsl_pkg::*;
();

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_GAP      = 13;
  localparam int RANDOM_WORDS = 1200;
  // The pipeline is twelve stages deep, so allow a margin when draining.
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT  = 500;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  pix_in_t  in_pixel;
  logic     out_strobe;
  pix_out_t out_pixel;

  // Predicted HSL words, oldest first.
  pix_out_t expected_hsl[$];
  int       fail_count = 0;
  int       idle_cycles = 0;
  // When set, the sender puts words in back to back.
  bit       no_idle;

  rgb888_to_hsl_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_strobe(out_strobe),
    .out_pixel (out_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Integer model of the conversion: exact rationals, truncated quotients.
  function automatic pix_out_t predict_hsl(input pix_in_t px);
    int unsigned r, g, b, hi, lo, d, sum, den, n;
    int unsigned hue, sat, lig;
    pix_out_t    res;
    r  = px.red;
    g  = px.green;
    b  = px.blue;
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    d  = hi - lo;
    if (d == 0) begin
      hue = 0;
      sat = 0;
      lig = (255 * hi) / 256;
    end else begin
      sum = hi + lo;
      lig = (255 * sum) / 512;
      den = (sum < 256) ? sum : (512 - sum);
      sat = (255 * d) / den;
      // Red wins a tie for the maximum, then green.
      if (r == hi) begin
        if (g >= b) n = g - b;
        else n = 6 * d - (b - g);
      end else if (g == hi) begin
        n = 2 * d + b - r;
      end else begin
        n = 4 * d + r - g;
      end
      hue = (255 * n) / (6 * d);
    end
    res.hue        = hue[7:0];
    res.saturation = sat[7:0];
    res.lightness  = lig[7:0];
    return res;
  endfunction

  // Sends one pixel word; called and returning at a falling edge.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    int      gap;
    pix_in_t px;
    gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
    px.red   = r;
    px.green = g;
    px.blue  = b;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (busy);
    expected_hsl.push_back(predict_hsl(px));
    @(negedge clk);
  endtask

  // Black, white and the grey levels either side of the midpoint.
  task automatic test_grey_levels();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd127, 8'd127, 8'd127);
    send_pixel(8'd128, 8'd128, 8'd128);
  endtask

  // Pure primaries and secondaries at full scale.
  task automatic test_primaries();
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
  endtask

  // Ties for the maximum, and red largest with blue above green.
  task automatic test_ties_and_wrap();
    send_pixel(8'd200, 8'd200, 8'd50);
    send_pixel(8'd200, 8'd50, 8'd200);
    send_pixel(8'd50, 8'd200, 8'd200);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd200, 8'd10, 8'd100);
  endtask

  // Channel sums either side of 256, where the saturation divisor changes.
  task automatic test_saturation_split();
    send_pixel(8'd254, 8'd1, 8'd50);
    send_pixel(8'd255, 8'd1, 8'd100);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
  endtask

  // Random pixels: mostly free channels, some grey, tied or extreme ones.
  task automatic test_random_pixels();
    int          kind;
    logic [7:0]  ch [3];
    int          edge_vals [4] = '{0, 1, 254, 255};
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Switch between idling and back-to-back stretches now and then.
      if (i % 64 == 0) no_idle = ($urandom_range(3, 0) == 0);
      kind = $urandom_range(9, 0);
      for (int c = 0; c < 3; c++) ch[c] = 8'($urandom_range(255, 0));
      case (kind)
        0: begin
          ch[1] = ch[0];
          ch[2] = ch[0];
        end
        1: begin
          // Random channels are set to 255 and red may copy green, to make ties likely.
          ch[$urandom_range(2, 0)] = 8'd255;
          ch[$urandom_range(2, 0)] = 8'd255;
          if ($urandom_range(1, 0) == 1) begin
            ch[0] = ch[1];
          end
        end
        2: begin
          for (int c = 0; c < 3; c++) begin
            if ($urandom_range(1, 0) == 1) ch[c] = 8'(edge_vals[$urandom_range(3, 0)]);
          end
        end
        default: ;
      endcase
      send_pixel(ch[0], ch[1], ch[2]);
    end
    no_idle = 1'b0;
  endtask

  // Compare each strobed result word with the oldest prediction.
  always @(posedge clk) begin
    pix_out_t exp_word;
    if (rst_n && out_strobe) begin
      if (expected_hsl.size() == 0) begin
        $error("unexpected result word: hue %0d saturation %0d lightness %0d",
               out_pixel.hue, out_pixel.saturation, out_pixel.lightness);
        fail_count++;
      end else begin
        exp_word = expected_hsl.pop_front();
        if (out_pixel.hue !== exp_word.hue) begin
          $error("hue: expected %0d, actual %0d", exp_word.hue, out_pixel.hue);
          fail_count++;
        end
        if (out_pixel.saturation !== exp_word.saturation) begin
          $error("saturation: expected %0d, actual %0d",
                 exp_word.saturation, out_pixel.saturation);
          fail_count++;
        end
        if (out_pixel.lightness !== exp_word.lightness) begin
          $error("lightness: expected %0d, actual %0d",
                 exp_word.lightness, out_pixel.lightness);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    no_idle     = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_pixel    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_grey_levels();
    test_primaries();
    test_ties_and_wrap();
    test_saturation_split();
    test_random_pixels();

    // Drain the pipeline, then give it a few more cycles.
    start <= 1'b0;
    while (expected_hsl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_hsl.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
